FILE: hw/rtl/clnw_pkg.sv
// Package for the character LCD nibble writer.
// Holds command codes, register indexes, field widths and display constants.
// No dependencies.
package clnw_pkg;

	localparam int CMD_W    = 3;
	localparam int CHAR_W   = 8;
	localparam int ROW_W    = 2;
	localparam int COL_W    = 6;
	localparam int LIMIT_W  = 8;
	localparam int NIB_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam int RUN_LEN = 10;
	localparam int CNT_W   = 4;

	localparam logic [COL_W-1:0] MAX_COLUMNS = 6'd40;

	localparam logic [7:0] DDRAM_BASE   = 8'h80;
	localparam logic [7:0] ROW_OFS_PAIR = 8'h14;
	localparam logic [7:0] ROW_OFS_ODD  = 8'h40;

	localparam logic [NIB_W-1:0] START_NIB_A = 4'h3;
	localparam logic [NIB_W-1:0] START_NIB_B = 4'h2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT       = 3'd0,
		CMD_CLEAR      = 3'd1,
		CMD_LOCATE     = 3'd2,
		CMD_PUT_CURSOR = 3'd3,
		CMD_PUT_POS    = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS         = 3'd0,
		CFG_COLUMNS      = 3'd1,
		CFG_FUNCTION_SET = 3'd2,
		CFG_DISPLAY_CTRL = 3'd3,
		CFG_ENTRY_MODE   = 3'd4,
		CFG_CLEAR        = 3'd5
	} cfg_idx_t;

endpackage

FILE: hw/rtl/clnw_if.sv
// Handshake channels of the character LCD nibble writer.
// Depends on clnw_pkg for field widths.
interface clnw_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [clnw_pkg::CMD_W-1:0]     cmd;
	logic [clnw_pkg::CHAR_W-1:0]    char_code;
	logic [clnw_pkg::ROW_W-1:0]     row;
	logic [clnw_pkg::COL_W-1:0]     column;
	logic [clnw_pkg::LIMIT_W-1:0]   char_limit;

	modport source (output valid, cmd, char_code, row, column, char_limit, input ready);
	modport sink (input valid, cmd, char_code, row, column, char_limit, output ready);
endinterface

interface clnw_nib_if;
	logic                         valid;
	logic                         ready;
	logic [clnw_pkg::NIB_W-1:0]   nibble;
	logic                         reg_select;
	logic                         last;

	modport source (output valid, nibble, reg_select, last, input ready);
	modport sink (input valid, nibble, reg_select, last, output ready);
endinterface

FILE: hw/rtl/char_lcd_nibble_writer.sv
// Character LCD nibble writer, top level.
// Depends on clnw_pkg and the channels in clnw_if.
// Turns LCD commands into tagged 4-bit bus writes.
//
// Each accepted command is expanded into its whole run of nibbles (init 10,
// clear 2, character writes 4, locate and empty-budget writes none) and held in a run
// register that shifts out one nibble per cycle, unless the bus side stalls, into the
// output register. The next command is taken in the cycle the last nibble of the current
// run moves to the output register, so a stall on the bus side holds the input only
// while the run register still holds nibbles. Cursor and budget update when the
// command is accepted.
module char_lcd_nibble_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	clnw_cmd_if.sink                          request,
	clnw_nib_if.source                        bus,
	input  logic                              cfg_we,
	input  logic [clnw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [clnw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [2:0]                        rows_q;
	logic [clnw_pkg::COL_W-1:0]        columns_q;
	logic [7:0]                        function_set_q;
	logic [7:0]                        display_ctrl_q;
	logic [7:0]                        entry_mode_q;
	logic [7:0]                        clear_code_q;

	logic [clnw_pkg::ROW_W-1:0]        cursor_row_q;
	logic [clnw_pkg::COL_W-1:0]        cursor_col_q;
	logic [clnw_pkg::LIMIT_W-1:0]      budget_q;

	logic [clnw_pkg::RUN_LEN-1:0][clnw_pkg::NIB_W-1:0] nib_s1;
	logic [clnw_pkg::RUN_LEN-1:0]                      rs_s1;
	logic [clnw_pkg::CNT_W-1:0]                        cnt_s1;

	logic                              out_valid_q;
	logic [clnw_pkg::NIB_W-1:0]        out_nib_q;
	logic                              out_rs_q;
	logic                              out_last_q;

	logic                              accept;
	logic                              load;

	logic [clnw_pkg::RUN_LEN-1:0][clnw_pkg::NIB_W-1:0] run_nib;
	logic [clnw_pkg::RUN_LEN-1:0]                      run_rs;
	logic [clnw_pkg::CNT_W-1:0]                        run_len;

	logic [clnw_pkg::COL_W-1:0]        cols;
	logic [clnw_pkg::ROW_W-1:0]        tgt_row;
	logic [clnw_pkg::COL_W-1:0]        tgt_col;
	logic [7:0]                        addr;
	logic [clnw_pkg::COL_W-1:0]        col_inc;
	logic [clnw_pkg::ROW_W-1:0]        adv_row;
	logic [clnw_pkg::COL_W-1:0]        adv_col;

	logic [clnw_pkg::ROW_W-1:0]        row_d;
	logic [clnw_pkg::COL_W-1:0]        col_d;
	logic [clnw_pkg::LIMIT_W-1:0]      budget_d;

	assign load   = (cnt_s1 != '0) && (!out_valid_q || bus.ready);
	assign request.ready = (cnt_s1 == '0) ||
		((cnt_s1 == clnw_pkg::CNT_W'(1)) && load);
	assign accept = request.valid && request.ready;

	assign cols = (columns_q > clnw_pkg::MAX_COLUMNS) ? clnw_pkg::MAX_COLUMNS : columns_q;

	assign tgt_row = (request.cmd == clnw_pkg::CMD_PUT_POS) ? request.row : cursor_row_q;
	assign tgt_col = (request.cmd == clnw_pkg::CMD_PUT_POS) ? request.column : cursor_col_q;

	always_comb begin
		if (({1'b0, tgt_row} < rows_q) && (tgt_col < cols)) begin
			addr = clnw_pkg::DDRAM_BASE
				+ (tgt_row[1] ? clnw_pkg::ROW_OFS_PAIR : 8'h00)
				+ (tgt_row[0] ? clnw_pkg::ROW_OFS_ODD : 8'h00)
				+ {2'b00, tgt_col};
		end else begin
			addr = clnw_pkg::DDRAM_BASE;
		end
	end

	always_comb begin
		col_inc = (tgt_col < cols) ? tgt_col + clnw_pkg::COL_W'(1) : tgt_col;
		if (col_inc >= cols) begin
			adv_row = (tgt_row == '0) ? clnw_pkg::ROW_W'(1) : '0;
			adv_col = '0;
		end else begin
			adv_row = tgt_row;
			adv_col = col_inc;
		end
	end

	always_comb begin
		run_nib  = '0;
		run_rs   = '0;
		run_len  = '0;
		row_d    = cursor_row_q;
		col_d    = cursor_col_q;
		budget_d = budget_q;
		unique case (request.cmd)
			clnw_pkg::CMD_INIT: begin
				run_nib[0] = clnw_pkg::START_NIB_A;
				run_nib[1] = clnw_pkg::START_NIB_A;
				run_nib[2] = clnw_pkg::START_NIB_A;
				run_nib[3] = clnw_pkg::START_NIB_B;
				run_nib[4] = function_set_q[7:4];
				run_nib[5] = function_set_q[3:0];
				run_nib[6] = display_ctrl_q[7:4];
				run_nib[7] = display_ctrl_q[3:0];
				run_nib[8] = entry_mode_q[7:4];
				run_nib[9] = entry_mode_q[3:0];
				run_len    = clnw_pkg::CNT_W'(clnw_pkg::RUN_LEN);
			end
			clnw_pkg::CMD_CLEAR: begin
				run_nib[0] = clear_code_q[7:4];
				run_nib[1] = clear_code_q[3:0];
				run_len    = clnw_pkg::CNT_W'(2);
				row_d      = '0;
				col_d      = '0;
			end
			clnw_pkg::CMD_LOCATE: begin
				row_d    = request.row;
				col_d    = request.column;
				budget_d = request.char_limit;
			end
			clnw_pkg::CMD_PUT_CURSOR, clnw_pkg::CMD_PUT_POS: begin
				if (request.cmd == clnw_pkg::CMD_PUT_POS || budget_q != '0) begin
					run_nib[0] = addr[7:4];
					run_nib[1] = addr[3:0];
					run_nib[2] = request.char_code[7:4];
					run_nib[3] = request.char_code[3:0];
					run_rs[2]  = 1'b1;
					run_rs[3]  = 1'b1;
					run_len    = clnw_pkg::CNT_W'(4);
					row_d      = adv_row;
					col_d      = adv_col;
					if (request.cmd == clnw_pkg::CMD_PUT_CURSOR) begin
						budget_d = budget_q - clnw_pkg::LIMIT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q         <= 3'd2;
			columns_q      <= 6'd16;
			function_set_q <= 8'h28;
			display_ctrl_q <= 8'h0C;
			entry_mode_q   <= 8'h06;
			clear_code_q   <= 8'h01;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clnw_pkg::CFG_ROWS:         rows_q         <= cfg_data[2:0];
				clnw_pkg::CFG_COLUMNS:      columns_q      <= cfg_data[clnw_pkg::COL_W-1:0];
				clnw_pkg::CFG_FUNCTION_SET: function_set_q <= cfg_data;
				clnw_pkg::CFG_DISPLAY_CTRL: display_ctrl_q <= cfg_data;
				clnw_pkg::CFG_ENTRY_MODE:   entry_mode_q   <= cfg_data;
				clnw_pkg::CFG_CLEAR:        clear_code_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			budget_q     <= '0;
			cnt_s1       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				cursor_row_q <= row_d;
				cursor_col_q <= col_d;
				budget_q     <= budget_d;
				cnt_s1       <= run_len;
			end else if (load) begin
				cnt_s1 <= cnt_s1 - clnw_pkg::CNT_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (bus.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nib_s1 <= run_nib;
			rs_s1  <= run_rs;
		end else if (load) begin
			nib_s1 <= {clnw_pkg::NIB_W'(0), nib_s1[clnw_pkg::RUN_LEN-1:1]};
			rs_s1  <= {1'b0, rs_s1[clnw_pkg::RUN_LEN-1:1]};
		end
		if (load) begin
			out_nib_q  <= nib_s1[0];
			out_rs_q   <= rs_s1[0];
			out_last_q <= (cnt_s1 == clnw_pkg::CNT_W'(1));
		end
	end

	assign bus.valid      = out_valid_q;
	assign bus.nibble     = out_nib_q;
	assign bus.reg_select = out_rs_q;
	assign bus.last       = out_last_q;

`ifndef NO_ASSERTIONS
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (cnt_s1 == clnw_pkg::CNT_W'(0) || cnt_s1 == clnw_pkg::CNT_W'(2) ||
			cnt_s1 == clnw_pkg::CNT_W'(4) || cnt_s1 == clnw_pkg::CNT_W'(10)))
		else $error("run length after accept is not a legal command length");

	a_budget: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && request.cmd == clnw_pkg::CMD_LOCATE) |=> budget_q <= $past(budget_q))
		else $error("budget grew without a locate");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s1 > clnw_pkg::CNT_W'(1)) |-> !request.ready)
		else $error("input taken while run register still holds nibbles");
`endif

endmodule

FILE: tb/tb_char_lcd_nibble_writer.sv
// Self-checking testbench for the character LCD nibble writer.
// Drives commands and register writes, predicts each nibble run, and checks the bus side.
// Depends on clnw_pkg, the channels in clnw_if and char_lcd_nibble_writer.
module tb_char_lcd_nibble_writer;
	timeunit 1ns;
	timeprecision 1ps;

	import clnw_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [CHAR_W-1:0]  char_code;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   column;
		logic [LIMIT_W-1:0] char_limit;
	} lcd_cmd_t;

	typedef struct {
		logic [NIB_W-1:0] nibble;
		logic             reg_select;
		logic             last;
	} bus_nib_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	clnw_cmd_if req_ch();
	clnw_nib_if nib_ch();

	char_lcd_nibble_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (req_ch),
		.bus       (nib_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// display settings and cursor state as the block should hold them
	logic [2:0] lcd_rows = 3'd2;
	logic [5:0] lcd_cols = 6'd16;
	logic [7:0] func_set_byte = 8'h28;
	logic [7:0] disp_ctrl_byte = 8'h0C;
	logic [7:0] entry_mode_byte = 8'h06;
	logic [7:0] clear_byte = 8'h01;
	logic [1:0] cur_row = '0;
	logic [5:0] cur_col = '0;
	logic [7:0] chars_left = '0;

	lcd_cmd_t pending_cmds[$];
	bus_nib_t expected_nibbles[$];
	lcd_cmd_t next_cmd;
	lcd_cmd_t got_cmd;
	bus_nib_t want;

	int queued = 0;
	int taken = 0;
	int mismatches = 0;
	int quiet = 0;
	int stall_asks = 0;
	int stall_done = 0;
	int stall_left = 0;
	bit calm = 1'b0;
	bit req_fire = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void emit(logic [NIB_W-1:0] n, logic rs);
		bus_nib_t e;
		e.nibble = n;
		e.reg_select = rs;
		e.last = 1'b0;
		expected_nibbles.push_back(e);
	endfunction

	function automatic void emit_byte(logic [7:0] b, logic rs);
		emit(b[7:4], rs);
		emit(b[3:0], rs);
	endfunction

	function automatic logic [5:0] col_cap();
		return (lcd_cols > MAX_COLUMNS) ? MAX_COLUMNS : lcd_cols;
	endfunction

	function automatic logic [7:0] ddram_addr(logic [1:0] r, logic [5:0] c);
		int a;
		if (r < lcd_rows && c < col_cap()) begin
			a = int'(DDRAM_BASE) + int'(r / 2) * int'(ROW_OFS_PAIR)
				+ int'(r % 2) * int'(ROW_OFS_ODD) + int'(c);
			return a[7:0];
		end
		return DDRAM_BASE;
	endfunction

	function automatic void write_char(logic [7:0] ch);
		logic [5:0] cap;
		cap = col_cap();
		emit_byte(ddram_addr(cur_row, cur_col), 1'b0);
		emit_byte(ch, 1'b1);
		if (cur_col < cap)
			cur_col = cur_col + 6'd1;
		if (cur_col >= cap) begin
			cur_row = (cur_row == 2'd0) ? 2'd1 : 2'd0;
			cur_col = '0;
		end
	endfunction

	function automatic void expand_command(lcd_cmd_t it);
		int first;
		bus_nib_t e;
		first = expected_nibbles.size();
		case (it.cmd)
			CMD_INIT: begin
				emit(START_NIB_A, 1'b0);
				emit(START_NIB_A, 1'b0);
				emit(START_NIB_A, 1'b0);
				emit(START_NIB_B, 1'b0);
				emit_byte(func_set_byte, 1'b0);
				emit_byte(disp_ctrl_byte, 1'b0);
				emit_byte(entry_mode_byte, 1'b0);
			end
			CMD_CLEAR: begin
				emit_byte(clear_byte, 1'b0);
				cur_row = '0;
				cur_col = '0;
			end
			CMD_LOCATE: begin
				cur_row = it.row;
				cur_col = it.column;
				chars_left = it.char_limit;
			end
			CMD_PUT_CURSOR: begin
				if (chars_left != '0) begin
					chars_left = chars_left - 8'd1;
					write_char(it.char_code);
				end
			end
			CMD_PUT_POS: begin
				cur_row = it.row;
				cur_col = it.column;
				write_char(it.char_code);
			end
			default: ;
		endcase
		if (expected_nibbles.size() > first) begin
			e = expected_nibbles.pop_back();
			e.last = 1'b1;
			expected_nibbles.push_back(e);
		end
	endfunction

	function automatic void send(logic [CMD_W-1:0] c, logic [CHAR_W-1:0] ch,
			logic [ROW_W-1:0] r, logic [COL_W-1:0] col, logic [LIMIT_W-1:0] lim);
		lcd_cmd_t it;
		it.cmd = c;
		it.char_code = ch;
		it.row = r;
		it.column = col;
		it.char_limit = lim;
		pending_cmds.push_back(it);
		queued++;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [ROW_W-1:0] rand_row();
		return ROW_W'($urandom_range(3));
	endfunction

	function automatic logic [COL_W-1:0] rand_any_col();
		return COL_W'($urandom_range(63));
	endfunction

	function automatic logic [COL_W-1:0] rand_column();
		if ($urandom_range(7) == 0)
			return rand_any_col();
		return COL_W'($urandom_range(int'(col_cap())));
	endfunction

	function automatic logic [LIMIT_W-1:0] rand_limit(int k);
		if ($urandom_range(7) == 0)
			return rand_byte();
		return LIMIT_W'($urandom_range(k + 2));
	endfunction

	// command side: hold the item until taken, then offer the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_fire) begin
		end else if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
			next_cmd = pending_cmds.pop_front();
			req_ch.valid <= 1'b1;
			req_ch.cmd <= next_cmd.cmd;
			req_ch.char_code <= next_cmd.char_code;
			req_ch.row <= next_cmd.row;
			req_ch.column <= next_cmd.column;
			req_ch.char_limit <= next_cmd.char_limit;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// bus side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			nib_ch.ready <= 1'b0;
		end else if (stall_done != stall_asks) begin
			stall_left = HOLD_CYCLES;
			stall_done++;
			nib_ch.ready <= 1'b0;
		end else begin
			nib_ch.ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		req_fire = arst_n && req_ch.valid && req_ch.ready;
		if (req_fire) begin
			got_cmd.cmd = req_ch.cmd;
			got_cmd.char_code = req_ch.char_code;
			got_cmd.row = req_ch.row;
			got_cmd.column = req_ch.column;
			got_cmd.char_limit = req_ch.char_limit;
			expand_command(got_cmd);
			taken++;
		end
		if (arst_n && nib_ch.valid && nib_ch.ready) begin
			if (expected_nibbles.size() == 0) begin
				$error("unexpected nibble %h reg_select %b last %b",
					nib_ch.nibble, nib_ch.reg_select, nib_ch.last);
				mismatches++;
			end else begin
				want = expected_nibbles.pop_front();
				if (nib_ch.nibble !== want.nibble) begin
					$error("nibble: expected %h, actual %h", want.nibble, nib_ch.nibble);
					mismatches++;
				end
				if (nib_ch.reg_select !== want.reg_select) begin
					$error("reg_select: expected %b, actual %b",
						want.reg_select, nib_ch.reg_select);
					mismatches++;
				end
				if (nib_ch.last !== want.last) begin
					$error("last: expected %b, actual %b", want.last, nib_ch.last);
					mismatches++;
				end
			end
		end
		if (req_fire || (nib_ch.valid && nib_ch.ready))
			quiet = 0;
		else
			quiet++;
	end

	initial begin
		while (quiet < QUIET_LIMIT)
			@(negedge clk);
		$error("no handshake for %0d cycles", QUIET_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic settle();
		while (taken != queued || expected_nibbles.size() != 0)
			@(negedge clk);
		repeat (RUN_LEN + 4) @(negedge clk);
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ROWS:         lcd_rows = val[2:0];
			CFG_COLUMNS:      lcd_cols = val[5:0];
			CFG_FUNCTION_SET: func_set_byte = val;
			CFG_DISPLAY_CTRL: disp_ctrl_byte = val;
			CFG_ENTRY_MODE:   entry_mode_byte = val;
			CFG_CLEAR:        clear_byte = val;
			default: ;
		endcase
	endtask

	task automatic set_display(logic [7:0] rows, logic [7:0] cols, logic [7:0] fs,
			logic [7:0] dc, logic [7:0] em, logic [7:0] clr);
		settle();
		put_reg(CFG_ROWS, rows);
		put_reg(CFG_COLUMNS, cols);
		put_reg(CFG_FUNCTION_SET, fs);
		put_reg(CFG_DISPLAY_CTRL, dc);
		put_reg(CFG_ENTRY_MODE, em);
		put_reg(CFG_CLEAR, clr);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int n);
		int made;
		int k;
		int p;
		made = 0;
		while (made < n) begin
			p = $urandom_range(99);
			if (p < 45) begin
				k = $urandom_range(1, 8);
				send(CMD_LOCATE, rand_byte(), rand_row(), rand_column(), rand_limit(k));
				repeat (k)
					send(CMD_PUT_CURSOR, rand_byte(), rand_row(), rand_any_col(),
						rand_byte());
				made += k + 1;
			end else begin
				if (p < 55)
					send(CMD_INIT, rand_byte(), rand_row(), rand_any_col(), rand_byte());
				else if (p < 65)
					send(CMD_CLEAR, rand_byte(), rand_row(), rand_any_col(), rand_byte());
				else if (p < 68)
					send(CMD_W'($urandom_range(5, 7)), rand_byte(), rand_row(),
						rand_any_col(), rand_byte());
				else if (p < 86)
					send(CMD_PUT_POS, rand_byte(), rand_row(), rand_column(), rand_byte());
				else if (p < 93)
					send(CMD_PUT_CURSOR, rand_byte(), rand_row(), rand_any_col(),
						rand_byte());
				else
					send(CMD_LOCATE, rand_byte(), rand_row(), rand_column(), rand_limit(4));
				made++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.char_code = '0;
		req_ch.row = '0;
		req_ch.column = '0;
		req_ch.char_limit = '0;
		nib_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: two rows of sixteen
		send(CMD_PUT_CURSOR, 8'h41, 2'd0, 6'd0, 8'd0);
		send(CMD_PUT_POS, 8'h00, 2'd0, 6'd0, 8'd0);
		send(CMD_INIT, 8'h00, 2'd0, 6'd0, 8'd0);
		send(CMD_CLEAR, 8'h00, 2'd0, 6'd0, 8'd0);
		send(CMD_LOCATE, 8'h00, 2'd1, 6'd15, 8'd3);
		send(CMD_PUT_CURSOR, 8'hFF, 2'd0, 6'd0, 8'd0);
		send(CMD_PUT_CURSOR, 8'hA5, 2'd0, 6'd0, 8'd0);
		send(CMD_PUT_CURSOR, 8'h5A, 2'd0, 6'd0, 8'd0);
		send(CMD_PUT_CURSOR, 8'h41, 2'd0, 6'd0, 8'd0);
		send(CMD_PUT_POS, 8'hFF, 2'd3, 6'd63, 8'hFF);
		send(CMD_PUT_POS, 8'h42, 2'd2, 6'd0, 8'd0);
		send(3'd5, 8'hFF, 2'd3, 6'd63, 8'hFF);
		send(3'd6, 8'h00, 2'd0, 6'd0, 8'd0);
		send(3'd7, 8'h55, 2'd1, 6'd21, 8'hAA);
		send(CMD_LOCATE, 8'h00, 2'd3, 6'd63, 8'd255);
		send(CMD_PUT_CURSOR, 8'h7E, 2'd0, 6'd0, 8'd0);
		send(CMD_LOCATE, 8'h00, 2'd0, 6'd0, 8'd0);
		send(CMD_PUT_CURSOR, 8'h43, 2'd0, 6'd0, 8'd0);

		// widest display, extreme command bytes
		set_display(8'd4, 8'd40, 8'hFF, 8'h00, 8'hFF, 8'h00);
		send(CMD_INIT, 8'h00, 2'd0, 6'd0, 8'd0);
		send(CMD_CLEAR, 8'h00, 2'd0, 6'd0, 8'd0);
		send(CMD_PUT_POS, 8'h30, 2'd3, 6'd39, 8'd0);
		send(CMD_PUT_POS, 8'h31, 2'd3, 6'd40, 8'd0);

		// smallest display
		set_display(8'd1, 8'd1, 8'h00, 8'hFF, 8'h00, 8'hFF);
		send(CMD_LOCATE, 8'h00, 2'd0, 6'd0, 8'd2);
		send(CMD_PUT_CURSOR, 8'h61, 2'd0, 6'd0, 8'd0);
		send(CMD_PUT_CURSOR, 8'h62, 2'd0, 6'd0, 8'd0);

		set_display(8'd2, 8'd16, rand_byte(), rand_byte(), rand_byte(), rand_byte());
		run_random(50);

		set_display(8'd4, 8'd40, rand_byte(), rand_byte(), rand_byte(), rand_byte());
		calm = 1'b1;
		run_random(50);
		settle();
		calm = 1'b0;

		// hold the bus off while commands keep coming
		set_display(8'd1, 8'd8, rand_byte(), rand_byte(), rand_byte(), rand_byte());
		run_random(50);
		stall_asks++;

		// column count above the cap
		set_display(8'd3, 8'd50, rand_byte(), rand_byte(), rand_byte(), rand_byte());
		run_random(50);

		set_display(8'($urandom_range(1, 4)), 8'($urandom_range(1, 40)), rand_byte(),
			rand_byte(), rand_byte(), rand_byte());
		run_random(50);

		settle();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/clnw_pkg.sv
hw/rtl/clnw_if.sv
hw/rtl/char_lcd_nibble_writer.sv
tb/tb_char_lcd_nibble_writer.sv
